>>> rtl/core/afgr_pkg.sv
// ----------------------------------------------------------------------------
// afgr_pkg
// shared widths, codes and state type of the fade gain ramp
// ----------------------------------------------------------------------------
package afgr_pkg;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int CMD_W    = 2;
   localparam int VOL_W    = 17;
   localparam int LEVEL_W  = 11;
   localparam int STEP_W   = 11;
   localparam int CSR_A_W  = 2;

   // datapath widths
   localparam int MAG_W    = SAMPLE_W + 1;          // sample magnitude, up to 32768
   localparam int P1_W     = MAG_W + LEVEL_W;       // magnitude times level
   localparam int PROD_W   = P1_W + VOL_W;          // times volume
   localparam int FRAC_W   = 16;                    // volume fraction bits
   localparam int T_W      = PROD_W + 1 - FRAC_W;   // dividend of the level division

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam int FADE_SAMPLES_DEF = 1024;

   // commands
   localparam logic [CMD_W-1:0] CMD_NONE     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FADE_IN  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FADE_OUT = 2'd2;

   // register indexes
   localparam logic [CSR_A_W-1:0] CSR_VOLUME        = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_FADE_IN_STEP  = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_FADE_OUT_STEP = 2'd2;

   localparam logic [VOL_W-1:0]  VOLUME_RESET = 17'h10000;
   localparam logic [STEP_W-1:0] STEP_RESET   = 11'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LEVEL,
      ST_MUL_VOL,
      ST_DIV,
      ST_DONE
   } afgr_state_type;

endpackage

>>> rtl/core/afgr_serial_mul.sv
// ----------------------------------------------------------------------------
// afgr_serial_mul
// bit-serial unsigned multiplier, one multiplier bit per cycle, lsb first
// ----------------------------------------------------------------------------
module afgr_serial_mul #(
   parameter int AW = 28,
   parameter int BW = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic             busy,
   output logic [AW+BW-1:0] product
);

   localparam int CNT_W = $clog2(BW + 1);

   logic [AW-1:0]    a_ff;
   logic [AW+BW-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]    addend;
   logic [AW:0]      sum;

   always_comb begin
      addend = acc_ff[0] ? a_ff : '0;
      sum    = {1'b0, acc_ff[AW+BW-1:BW]} + {1'b0, addend};
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (start) begin
         acc_in = {{AW{1'b0}}, b};
         cnt_in = CNT_W'(BW);
      end else if (cnt_ff != '0) begin
         // add, then shift the partial product right by one
         acc_in = {sum, acc_ff[BW-1:1]};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
      end
      acc_ff <= acc_in;
   end

   assign busy    = (cnt_ff != '0);
   assign product = acc_ff;

endmodule

>>> rtl/core/afgr_serial_div.sv
// ----------------------------------------------------------------------------
// afgr_serial_div
// restoring divider by a constant, one quotient bit per cycle, msb first
// ----------------------------------------------------------------------------
module afgr_serial_div #(
   parameter int NW      = 30,
   parameter int DIVISOR = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   output logic          busy,
   output logic [NW-1:0] quotient
);

   localparam int DW    = $clog2(DIVISOR + 1);
   localparam int CNT_W = $clog2(NW + 1);
   localparam logic [DW:0] DIV_C = (DW+1)'(DIVISOR);

   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW:0]      trial;
   logic [DW:0]      diff;
   logic             fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[NW-1]};
      fits   = (trial >= DIV_C);
      diff   = trial - DIV_C;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(NW);
      end else if (cnt_ff != '0) begin
         // dividend bits leave at the top, quotient bits enter at the bottom
         quo_in = {quo_ff[NW-2:0], fits};
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

>>> rtl/core/audio_fade_gain_ramp_top.sv
// ----------------------------------------------------------------------------
// audio_fade_gain_ramp_top
// per-sample volume scaling with a linear fade-in / fade-out ramp
// each accepted item takes two passes through the shared bit-serial multiplier
//   and one through the bit-serial divider; a new item is taken only once the
//   result of the last one is in the output register
// reset (synchronous): level 0, fading in, volume unity, both steps 1
// ----------------------------------------------------------------------------
module audio_fade_gain_ramp_top #(
   parameter int FADE_SAMPLES = afgr_pkg::FADE_SAMPLES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [afgr_pkg::REQ_DATA_W-1:0]   req_tdata,  // command, sample_in, zero pad
   input  logic                              req_tlast,  // block_end
   // result items
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [afgr_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // sample_out, level_after,
                                                         // fade_out_done, zero pad
   output logic                              rsp_tlast,  // block_end_out
   // register writes
   input  logic                              csr_we,
   input  logic [afgr_pkg::CSR_A_W-1:0]      csr_addr,
   input  logic [afgr_pkg::VOL_W-1:0]        csr_wdata
);

   localparam int SW  = afgr_pkg::SAMPLE_W;
   localparam int LW  = afgr_pkg::LEVEL_W;
   localparam int PW  = afgr_pkg::PROD_W;
   localparam int TW  = afgr_pkg::T_W;
   localparam int MW  = afgr_pkg::MAG_W;
   localparam int AW  = afgr_pkg::P1_W;
   localparam int BW  = afgr_pkg::VOL_W;
   localparam int SPW = afgr_pkg::STEP_W;

   // rounding: add half of 65536 * FADE_SAMPLES before the division
   localparam logic [PW:0]   HALF_DEN   = (PW+1)'(FADE_SAMPLES * 32768);
   localparam logic [LW-1:0] LEVEL_MAX  = LW'(FADE_SAMPLES);
   localparam logic [LW:0]   LEVEL_MAXW = (LW+1)'(FADE_SAMPLES);
   localparam logic [MW-1:0] POS_LIM    = MW'(32767);
   localparam logic [MW-1:0] NEG_LIM    = MW'(32768);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [BW-1:0]  volume_ff;
   logic [SPW-1:0] in_step_ff;
   logic [SPW-1:0] out_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff   <= afgr_pkg::VOLUME_RESET;
         in_step_ff  <= afgr_pkg::STEP_RESET;
         out_step_ff <= afgr_pkg::STEP_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            afgr_pkg::CSR_VOLUME:        volume_ff   <= csr_wdata;
            afgr_pkg::CSR_FADE_IN_STEP:  in_step_ff  <= csr_wdata[SPW-1:0];
            afgr_pkg::CSR_FADE_OUT_STEP: out_step_ff <= csr_wdata[SPW-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // input item fields
   // ---------------------------------------------------------------------
   logic [afgr_pkg::CMD_W-1:0] req_cmd;
   logic [SW-1:0]              req_sample;
   logic                       req_accept;

   assign req_cmd    = req_tdata[afgr_pkg::CMD_W-1:0];
   assign req_sample = req_tdata[afgr_pkg::CMD_W +: SW];
   assign req_accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------------
   // fade state: command first, then the level step, all at accept time;
   // the level before the step feeds the multiplier
   // ---------------------------------------------------------------------
   logic [LW-1:0] fade_level_ff, fade_level_in;
   logic          fading_out_ff, fading_out_in;
   logic [LW-1:0] level_eff;
   logic [LW:0]   level_sum;
   logic [MW-1:0] mag_in;

   always_comb begin
      level_eff     = fade_level_ff;
      fading_out_in = fading_out_ff;
      if (req_cmd == afgr_pkg::CMD_FADE_IN) begin
         level_eff     = '0;
         fading_out_in = 1'b0;
      end else if (req_cmd == afgr_pkg::CMD_FADE_OUT) begin
         fading_out_in = 1'b1;
      end

      level_sum = {1'b0, level_eff} + {1'b0, in_step_ff};
      if (fading_out_in) begin
         fade_level_in = (out_step_ff >= level_eff) ? '0 : (level_eff - out_step_ff);
      end else begin
         fade_level_in = (level_sum > LEVEL_MAXW) ? LEVEL_MAX : level_sum[LW-1:0];
      end

      // magnitude of the sample, 32768 for the most negative code
      mag_in = req_sample[SW-1] ? (MW'(1 << SW) - {1'b0, req_sample})
                                : {1'b0, req_sample};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_level_ff <= '0;
         fading_out_ff <= 1'b0;
      end else if (req_accept) begin
         fade_level_ff <= fade_level_in;
         fading_out_ff <= fading_out_in;
      end
   end

   // per-item values held until the result is formed
   logic          neg_ff;
   logic          last_ff;
   logic [LW-1:0] level_after_ff;
   logic          done_flag_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         neg_ff         <= req_sample[SW-1];
         last_ff        <= req_tlast;
         level_after_ff <= fade_level_in;
         done_flag_ff   <= fading_out_in && (fade_level_in == '0);
      end
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   afgr_pkg::afgr_state_type state_ff, state_in;

   logic          mul_start;
   logic          mul_busy;
   logic [AW-1:0] mul_a;
   logic [BW-1:0] mul_b;
   logic [PW-1:0] mul_prod;
   logic          div_start;
   logic          div_busy;
   logic [TW-1:0] div_dividend;
   logic [TW-1:0] div_quo;
   logic [PW:0]   rounded;
   logic          rsp_load;
   logic          rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         afgr_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = afgr_pkg::ST_MUL_LEVEL;
         end
         afgr_pkg::ST_MUL_LEVEL: begin
            if (!mul_busy) state_in = afgr_pkg::ST_MUL_VOL;
         end
         afgr_pkg::ST_MUL_VOL: begin
            if (!mul_busy) state_in = afgr_pkg::ST_DIV;
         end
         afgr_pkg::ST_DIV: begin
            if (!div_busy) state_in = afgr_pkg::ST_DONE;
         end
         afgr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = afgr_pkg::ST_IDLE;
         end
         default: state_in = afgr_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      mul_start  = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      // first pass: magnitude times level, second pass: that times volume
      mul_a      = mul_prod[AW-1:0];
      mul_b      = volume_ff;
      case (state_ff)
         afgr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            mul_start  = req_tvalid;
            mul_a      = AW'(mag_in);
            mul_b      = BW'(level_eff);
         end
         afgr_pkg::ST_MUL_LEVEL: begin
            mul_start = !mul_busy;
         end
         afgr_pkg::ST_MUL_VOL: begin
            div_start = !mul_busy;
         end
         afgr_pkg::ST_DIV: ;
         afgr_pkg::ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= afgr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------
   // arithmetic units
   // ---------------------------------------------------------------------
   afgr_serial_mul #(
      .AW (AW),
      .BW (BW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .busy    (mul_busy),
      .product (mul_prod)
   );

   // drop the volume fraction after adding the rounding half
   assign rounded      = {1'b0, mul_prod} + HALF_DEN;
   assign div_dividend = rounded[PW:afgr_pkg::FRAC_W];

   afgr_serial_div #(
      .NW      (TW),
      .DIVISOR (FADE_SAMPLES)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------------
   // saturation, sign and output register
   // ---------------------------------------------------------------------
   logic [MW-1:0] sat_lim;
   logic [MW-1:0] q_sat;
   logic [SW-1:0] sample_res;

   always_comb begin
      sat_lim    = neg_ff ? NEG_LIM : POS_LIM;
      q_sat      = (div_quo > TW'(sat_lim)) ? sat_lim : div_quo[MW-1:0];
      sample_res = neg_ff ? SW'(MW'(0) - q_sat) : q_sat[SW-1:0];
   end

   logic [SW-1:0] rsp_sample_ff;
   logic [LW-1:0] rsp_level_ff;
   logic          rsp_done_ff;
   logic          rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sample_ff <= sample_res;
         rsp_level_ff  <= level_after_ff;
         rsp_done_ff   <= done_flag_ff;
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(afgr_pkg::RSP_DATA_W - SW - LW - 1){1'b0}},
                        rsp_done_ff, rsp_level_ff, rsp_sample_ff};

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // the ramp never leaves 0..FADE_SAMPLES
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      fade_level_ff <= LEVEL_MAX)
      else $error("fade level above full scale");

   // the shared multiplier is idle whenever a new item can enter
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == afgr_pkg::ST_IDLE) |-> !mul_busy)
      else $error("multiplier busy while idle");

   // the divider is never started while the multiplier or the divider still runs
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (!mul_busy && !div_busy))
      else $error("divider started too early");

   // a finished fade-out always reports a silent level
   a_done_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_level_ff == '0))
      else $error("fade-out done with non-zero level");

endmodule
